// ===== src/jfc_pkg.sv =====
// Shared types, constants and helpers for the joystick frame checker.
package jfc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SUM_W    = 12;
    localparam int unsigned SCALED_W = 11;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned OUT_W    = 48;

    // Fixed byte positions inside a frame
    localparam int unsigned POS_START  = 0;
    localparam int unsigned POS_THRUST = 1;
    localparam int unsigned POS_ROLL   = 2;
    localparam int unsigned POS_PITCH  = 3;
    localparam int unsigned POS_YAW    = 4;
    localparam int unsigned POS_MODE   = 5;
    localparam int unsigned POS_MARKER = 6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER_VALUE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRUST_OFFSET = 2'd2;

    localparam logic [BYTE_W-1:0] START_VALUE_RST   = 8'd253;
    localparam logic [BYTE_W-1:0] MARKER_VALUE_RST  = 8'd173;
    localparam logic [BYTE_W-1:0] THRUST_OFFSET_RST = 8'd75;

    // ceil(2^13 / 3); exact floor(m/3) for m up to 2048
    localparam logic [12:0] THIRD_RECIP = 13'd2731;
    localparam int unsigned THIRD_SHIFT = 13;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_CHECKSUM = 2'd1,
        STAT_START    = 2'd2,
        STAT_MARKER   = 2'd3
    } t_status;

    typedef struct packed {
        logic [SUM_W-1:0]           sum;
        logic                       start_ok;
        logic                       marker_ok;
        logic [BYTE_W-1:0]          thrust_raw;
        logic signed [SCALED_W-1:0] roll;
        logic signed [SCALED_W-1:0] pitch;
        logic signed [BYTE_W-1:0]   yaw;
        logic [BYTE_W-1:0]          mode;
        logic [BYTE_W-1:0]          chk_low;
    } t_frame_state;

    // Signed byte times 16, divided by three, truncated toward zero
    function automatic logic signed [SCALED_W-1:0] scale_third(input logic [BYTE_W-1:0] b);
        logic [SUM_W-1:0]          x;
        logic [SUM_W-1:0]          mag;
        logic [SUM_W+12:0]         prod;
        logic [SCALED_W-1:0]       q;
        x    = {b, 4'b0000};
        mag  = b[BYTE_W-1] ? (~x + 1'b1) : x;
        prod = mag * THIRD_RECIP;
        q    = prod[THIRD_SHIFT +: SCALED_W];
        return b[BYTE_W-1] ? signed'(~q + 1'b1) : signed'(q);
    endfunction

endpackage

// ===== src/jfc_frame_acc.sv =====
// Byte position counter, running checksum and field capture for one frame.
module jfc_frame_acc #(
    parameter int unsigned FRAME_BYTES = 9
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [jfc_pkg::BYTE_W-1:0]  i_byte,
    input  logic [jfc_pkg::BYTE_W-1:0]  i_start_value,
    input  logic [jfc_pkg::BYTE_W-1:0]  i_marker_value,
    output jfc_pkg::t_frame_state       o_state,
    output logic                        o_last
);

    localparam int unsigned POS_W = $clog2(FRAME_BYTES);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] CHK_POS  = POS_W'(FRAME_BYTES - 2);

    logic [POS_W-1:0]                     r_pos, n_pos;
    logic [jfc_pkg::SUM_W-1:0]            r_sum, n_sum;
    logic                                 r_start_ok, n_start_ok;
    logic                                 r_marker_ok, n_marker_ok;
    logic [jfc_pkg::BYTE_W-1:0]           r_thrust_raw;
    logic signed [jfc_pkg::SCALED_W-1:0]  r_roll;
    logic signed [jfc_pkg::SCALED_W-1:0]  r_pitch;
    logic signed [jfc_pkg::BYTE_W-1:0]    r_yaw;
    logic [jfc_pkg::BYTE_W-1:0]           r_mode;
    logic [jfc_pkg::BYTE_W-1:0]           r_chk_low;

    assign o_last = (r_pos == LAST_POS);

    always_comb begin
        n_pos       = r_pos;
        n_sum       = r_sum;
        n_start_ok  = r_start_ok;
        n_marker_ok = r_marker_ok;
        if (i_fire) begin
            if (r_pos < CHK_POS) begin
                n_sum = r_sum + {{(jfc_pkg::SUM_W-jfc_pkg::BYTE_W){i_byte[jfc_pkg::BYTE_W-1]}},
                                 i_byte};
                if (r_pos == POS_W'(jfc_pkg::POS_START)) begin
                    n_start_ok = (i_byte == i_start_value);
                end
                if (r_pos == POS_W'(jfc_pkg::POS_MARKER)) begin
                    n_marker_ok = (i_byte == i_marker_value);
                end
                n_pos = r_pos + 1'b1;
            end else if (r_pos == CHK_POS) begin
                n_pos = r_pos + 1'b1;
            end else begin
                // last word: start the next frame
                n_pos       = '0;
                n_sum       = '0;
                n_start_ok  = 1'b0;
                n_marker_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_sum       <= '0;
            r_start_ok  <= 1'b0;
            r_marker_ok <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_start_ok  <= n_start_ok;
            r_marker_ok <= n_marker_ok;
        end
    end

    // Payload capture; roll and pitch are scaled on the way in
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            if (r_pos == POS_W'(jfc_pkg::POS_THRUST)) r_thrust_raw <= i_byte;
            if (r_pos == POS_W'(jfc_pkg::POS_ROLL))
                r_roll <= jfc_pkg::scale_third(i_byte);
            if (r_pos == POS_W'(jfc_pkg::POS_PITCH))
                r_pitch <= jfc_pkg::scale_third(i_byte);
            if (r_pos == POS_W'(jfc_pkg::POS_YAW)) r_yaw <= signed'(i_byte);
            if (r_pos == POS_W'(jfc_pkg::POS_MODE)) r_mode <= i_byte;
            if (r_pos == CHK_POS) r_chk_low <= i_byte;
        end
    end

    always_comb begin
        o_state.sum        = r_sum;
        o_state.start_ok   = r_start_ok;
        o_state.marker_ok  = r_marker_ok;
        o_state.thrust_raw = r_thrust_raw;
        o_state.roll       = r_roll;
        o_state.pitch      = r_pitch;
        o_state.yaw        = r_yaw;
        o_state.mode       = r_mode;
        o_state.chk_low    = r_chk_low;
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_POS)
        else $error("frame position past last byte");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_last) |=> (r_pos == '0 && r_sum == '0 && !r_start_ok && !r_marker_ok))
        else $error("frame state not cleared after last byte");

    a_marker_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_marker_ok) |-> $past(i_fire && r_pos == POS_W'(jfc_pkg::POS_MARKER)))
        else $error("marker flag set away from marker position");

endmodule

// ===== src/jfc_result.sv =====
// Frame verdict and result output register.
module jfc_result (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire_last,
    input  logic [jfc_pkg::BYTE_W-1:0]  i_byte,
    input  jfc_pkg::t_frame_state       i_state,
    input  logic [jfc_pkg::BYTE_W-1:0]  i_thrust_offset,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [jfc_pkg::OUT_W-1:0]   o_out_data
);

    logic                                 r_valid;
    jfc_pkg::t_status                     r_status, n_status;
    logic [jfc_pkg::BYTE_W-1:0]           r_thrust, n_thrust;
    logic signed [jfc_pkg::SCALED_W-1:0]  r_roll, n_roll;
    logic signed [jfc_pkg::SCALED_W-1:0]  r_pitch, n_pitch;
    logic signed [jfc_pkg::BYTE_W-1:0]    r_yaw, n_yaw;
    logic [jfc_pkg::BYTE_W-1:0]           r_mode, n_mode;
    logic [15:0]                          recv_chk;
    logic [15:0]                          sum_ext;

    assign recv_chk = {i_byte, i_state.chk_low};
    assign sum_ext  = {{(16-jfc_pkg::SUM_W){i_state.sum[jfc_pkg::SUM_W-1]}}, i_state.sum};

    always_comb begin
        priority if (recv_chk != sum_ext) n_status = jfc_pkg::STAT_CHECKSUM;
        else if (!i_state.start_ok)       n_status = jfc_pkg::STAT_START;
        else if (!i_state.marker_ok)      n_status = jfc_pkg::STAT_MARKER;
        else                              n_status = jfc_pkg::STAT_OK;
    end

    always_comb begin
        if (n_status == jfc_pkg::STAT_OK) begin
            n_thrust = i_state.thrust_raw + i_thrust_offset;
            n_roll   = i_state.roll;
            n_pitch  = i_state.pitch;
            n_yaw    = i_state.yaw;
            n_mode   = i_state.mode;
        end else begin
            n_thrust = '0;
            n_roll   = '0;
            n_pitch  = '0;
            n_yaw    = '0;
            n_mode   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire_last) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire_last) begin
            r_status <= n_status;
            r_thrust <= n_thrust;
            r_roll   <= n_roll;
            r_pitch  <= n_pitch;
            r_yaw    <= n_yaw;
            r_mode   <= n_mode;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = {r_mode, r_yaw, r_pitch, r_roll, r_thrust, r_status};

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(i_fire_last))
        else $error("result raised without a last byte");

    a_last_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire_last |=> r_valid)
        else $error("last byte did not load a result");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != jfc_pkg::STAT_OK) |->
        (r_thrust == '0 && r_roll == '0 && r_pitch == '0 && r_yaw == '0 && r_mode == '0))
        else $error("failed frame carries nonzero fields");

endmodule

// ===== src/joystick_frame_checker_unit.sv =====
// Top level of the joystick frame checker: stream ports and register file.
//
// Takes one received byte per cycle and cuts the stream into frames of
// FRAME_BYTES bytes by count alone, starting at reset. The last byte of a
// frame loads a one-word result register, so a sustained rate of one byte
// per clock holds as long as results are drained. Only the last byte of a
// frame waits when a previous result is still unaccepted. The result word
// carries a status (checksum, then start byte, then marker byte at position
// six) and the decoded stick fields, all zero when the status is not ok.
// Registers must be written through the plain write port only while the
// stream is idle; the block itself does not enforce this.
module joystick_frame_checker_unit #(
    parameter int unsigned FRAME_BYTES = 9
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [7:0]                       i_s_axis_tdata,  // [7:0] rx_byte
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [1:0] status, [9:2] thrust, [20:10] roll_scaled, [31:21] pitch_scaled,
    // [39:32] yaw, [47:40] mode
    output logic [jfc_pkg::OUT_W-1:0]        o_m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [jfc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [jfc_pkg::BYTE_W-1:0]       i_cfg_wdata
);

    logic [jfc_pkg::BYTE_W-1:0] r_start_value;
    logic [jfc_pkg::BYTE_W-1:0] r_marker_value;
    logic [jfc_pkg::BYTE_W-1:0] r_thrust_offset;

    jfc_pkg::t_frame_state frame_state;
    logic                  frame_last;
    logic                  in_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_value   <= jfc_pkg::START_VALUE_RST;
            r_marker_value  <= jfc_pkg::MARKER_VALUE_RST;
            r_thrust_offset <= jfc_pkg::THRUST_OFFSET_RST;
        end else if (i_cfg_we) begin
            // drop writes to unused indexes
            unique case (i_cfg_index)
                jfc_pkg::CFG_START_VALUE:   r_start_value   <= i_cfg_wdata;
                jfc_pkg::CFG_MARKER_VALUE:  r_marker_value  <= i_cfg_wdata;
                jfc_pkg::CFG_THRUST_OFFSET: r_thrust_offset <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Hold only the last word of a frame while a result is pending and not taken
    assign o_s_axis_tready = !frame_last || !o_m_axis_tvalid || i_m_axis_tready;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    jfc_frame_acc #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame_acc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (in_fire),
        .i_byte         (i_s_axis_tdata),
        .i_start_value  (r_start_value),
        .i_marker_value (r_marker_value),
        .o_state        (frame_state),
        .o_last         (frame_last)
    );

    jfc_result u_result (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire_last     (in_fire && frame_last),
        .i_byte          (i_s_axis_tdata),
        .i_state         (frame_state),
        .i_thrust_offset (r_thrust_offset),
        .i_out_ready     (i_m_axis_tready),
        .o_out_valid     (o_m_axis_tvalid),
        .o_out_data      (o_m_axis_tdata)
    );

endmodule

// ===== tb/tb_joystick_frame_checker_unit.sv =====
// Testbench for the joystick frame checker: byte stream in, decoded frame reports checked.
module tb_joystick_frame_checker_unit;

    localparam int unsigned FRAME_BYTES  = 9;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned CFG_SETTLE   = 4;
    localparam logic [jfc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct {
        jfc_pkg::t_status                    status;
        logic [jfc_pkg::BYTE_W-1:0]          thrust;
        logic signed [jfc_pkg::SCALED_W-1:0] roll;
        logic signed [jfc_pkg::SCALED_W-1:0] pitch;
        logic signed [jfc_pkg::BYTE_W-1:0]   yaw;
        logic [jfc_pkg::BYTE_W-1:0]          mode;
    } t_stick_report;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          rx_valid  = 1'b0;
    logic [jfc_pkg::BYTE_W-1:0]    rx_data   = '0;
    logic                          rep_ready = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [jfc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [jfc_pkg::BYTE_W-1:0]    cfg_wdata = '0;
    logic                          rx_ready;
    logic                          rep_valid;
    logic [jfc_pkg::OUT_W-1:0]     rep_data;

    // frame decoder state and its copy of the registers
    int unsigned                dec_pos;
    logic [jfc_pkg::SUM_W-1:0]  dec_sum;
    logic [jfc_pkg::BYTE_W-1:0] dec_fields [5];
    logic                       dec_start_ok;
    logic                       dec_marker_ok;
    logic [jfc_pkg::BYTE_W-1:0] dec_chk_low;
    logic [jfc_pkg::BYTE_W-1:0] reg_start;
    logic [jfc_pkg::BYTE_W-1:0] reg_marker;
    logic [jfc_pkg::BYTE_W-1:0] reg_offset;

    t_stick_report              pending_reports [$];
    logic [jfc_pkg::BYTE_W-1:0] frame_buf [FRAME_BYTES];

    int          err_count    = 0;
    int          reports_seen = 0;
    int          bytes_sent   = 0;
    int          stall_cycles = 0;
    int          cfg_writes   = 0;
    int          status_seen [4] = '{0, 0, 0, 0};
    bit          idle_on      = 1'b1;
    int unsigned hold_left    = 0;
    int unsigned stall_left   = 0;
    int unsigned cycle_count  = 0;

    always #1 clk = ~clk;

    joystick_frame_checker_unit #(
        .FRAME_BYTES(FRAME_BYTES)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(rx_valid),
        .o_s_axis_tready(rx_ready),
        .i_s_axis_tdata (rx_data),
        .o_m_axis_tvalid(rep_valid),
        .i_m_axis_tready(rep_ready),
        .o_m_axis_tdata (rep_data),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata)
    );

    // signed byte as Q.4, divided by three, truncated toward zero
    function automatic logic signed [jfc_pkg::SCALED_W-1:0] third_q4(
            input logic [jfc_pkg::BYTE_W-1:0] b);
        int q;
        q = (int'(signed'(b)) * 16) / 3;
        return q[jfc_pkg::SCALED_W-1:0];
    endfunction

    task automatic reset_decoder();
        reg_start     = jfc_pkg::START_VALUE_RST;
        reg_marker    = jfc_pkg::MARKER_VALUE_RST;
        reg_offset    = jfc_pkg::THRUST_OFFSET_RST;
        dec_pos       = 0;
        dec_sum       = '0;
        dec_start_ok  = 1'b0;
        dec_marker_ok = 1'b0;
        dec_chk_low   = '0;
        for (int k = 0; k < 5; k++) dec_fields[k] = '0;
    endtask

    task automatic decode_rx_byte(input logic [jfc_pkg::BYTE_W-1:0] b);
        t_stick_report rep;
        int            recv;
        if (dec_pos < FRAME_BYTES - 2) begin
            dec_sum = dec_sum + {{(jfc_pkg::SUM_W-jfc_pkg::BYTE_W){b[jfc_pkg::BYTE_W-1]}}, b};
            if (dec_pos == jfc_pkg::POS_START) dec_start_ok = (b == reg_start);
            if (dec_pos == jfc_pkg::POS_MARKER) dec_marker_ok = (b == reg_marker);
            if (dec_pos >= jfc_pkg::POS_THRUST && dec_pos <= jfc_pkg::POS_MODE)
                dec_fields[dec_pos - jfc_pkg::POS_THRUST] = b;
            dec_pos++;
        end else if (dec_pos == FRAME_BYTES - 2) begin
            dec_chk_low = b;
            dec_pos++;
        end else begin
            recv       = int'(signed'({b, dec_chk_low}));
            rep.thrust = '0;
            rep.roll   = '0;
            rep.pitch  = '0;
            rep.yaw    = '0;
            rep.mode   = '0;
            if (int'(signed'(dec_sum)) != recv) rep.status = jfc_pkg::STAT_CHECKSUM;
            else if (!dec_start_ok) rep.status = jfc_pkg::STAT_START;
            else if (!dec_marker_ok) rep.status = jfc_pkg::STAT_MARKER;
            else rep.status = jfc_pkg::STAT_OK;
            if (rep.status == jfc_pkg::STAT_OK) begin
                rep.thrust = dec_fields[0] + reg_offset;
                rep.roll   = third_q4(dec_fields[1]);
                rep.pitch  = third_q4(dec_fields[2]);
                rep.yaw    = dec_fields[3];
                rep.mode   = dec_fields[4];
            end
            pending_reports.push_back(rep);
            dec_pos       = 0;
            dec_sum       = '0;
            dec_start_ok  = 1'b0;
            dec_marker_ok = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    task automatic check_report(input logic [jfc_pkg::OUT_W-1:0] word);
        t_stick_report want;
        if (pending_reports.size() == 0) begin
            $error("report word %h arrived with none pending", word);
            err_count++;
        end else begin
            want = pending_reports.pop_front();
            check_field("status", want.status, word[1:0]);
            check_field("thrust", want.thrust, word[9:2]);
            check_field("roll_scaled", want.roll, signed'(word[20:10]));
            check_field("pitch_scaled", want.pitch, signed'(word[31:21]));
            check_field("yaw", want.yaw, signed'(word[39:32]));
            check_field("mode", want.mode, word[47:40]);
            status_seen[want.status]++;
            reports_seen++;
        end
    endtask

    // report sink: check each accepted word, then pick ready for the next edge
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && rep_valid && rep_ready) check_report(rep_data);
            if (hold_left > 0) begin
                hold_left--;
                rep_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rep_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                rep_ready <= 1'b0;
            end else begin
                rep_ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_joystick_frame_checker_unit: done, errors");
        $finish;
    end

    // hold valid across words; drop it only for a random gap
    task automatic send_byte(input logic [jfc_pkg::BYTE_W-1:0] b);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_data  <= b;
        @(posedge clk);
        while (!rx_ready) begin
            stall_cycles++;
            @(posedge clk);
        end
        decode_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        rx_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [jfc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [jfc_pkg::BYTE_W-1:0] val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            jfc_pkg::CFG_START_VALUE:   reg_start  = val;
            jfc_pkg::CFG_MARKER_VALUE:  reg_marker = val;
            jfc_pkg::CFG_THRUST_OFFSET: reg_offset = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_byte($urandom_range(0, 255));
    endtask

    // pad the current frame out so the next word lands at the start position
    task automatic align_frame();
        while (dec_pos != 0) send_byte($urandom_range(0, 255));
    endtask

    // fields, low byte first: thrust, roll, pitch, yaw, mode
    function automatic void build_frame(input bit bad_sum, input bit bad_start,
                                        input bit bad_marker, input logic [39:0] fields);
        int          sum;
        logic [15:0] chk;
        frame_buf[jfc_pkg::POS_START] = bad_start ? reg_start ^ 8'($urandom_range(1, 255))
                                                  : reg_start;
        for (int k = 0; k < 5; k++) frame_buf[jfc_pkg::POS_THRUST + k] = fields[8*k +: 8];
        frame_buf[jfc_pkg::POS_MARKER] = bad_marker ? reg_marker ^ 8'($urandom_range(1, 255))
                                                    : reg_marker;
        for (int k = jfc_pkg::POS_MARKER + 1; k < FRAME_BYTES - 2; k++)
            frame_buf[k] = 8'($urandom_range(0, 255));
        sum = 0;
        for (int k = 0; k < FRAME_BYTES - 2; k++) sum += int'(signed'(frame_buf[k]));
        chk = sum[15:0];
        if (bad_sum) chk ^= 16'($urandom_range(1, 65535));
        frame_buf[FRAME_BYTES-2] = chk[7:0];
        frame_buf[FRAME_BYTES-1] = chk[15:8];
    endfunction

    task automatic send_span(input int first, input int last);
        for (int k = first; k <= last; k++) send_byte(frame_buf[k]);
    endtask

    task automatic send_frame(input bit bad_sum, input bit bad_start, input bit bad_marker,
                              input logic [39:0] fields);
        align_frame();
        build_frame(bad_sum, bad_start, bad_marker, fields);
        send_span(0, FRAME_BYTES - 1);
    endtask

    function automatic logic [39:0] random_fields();
        return {8'($urandom), 32'($urandom)};
    endfunction

    // mostly well-formed frames, with faulty frames and loose bytes mixed in
    task automatic send_random_frame();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) send_frame(0, 0, 0, random_fields());
        else if (pick < 78) send_frame(1, 0, 0, random_fields());
        else if (pick < 84) send_frame(0, 1, 0, random_fields());
        else if (pick < 90) send_frame(0, 0, 1, random_fields());
        else if (pick < 93) send_frame(1, 1, 1, random_fields());
        else if (pick < 97) send_noise($urandom_range(1, 12));
        else send_frame(0, 1, 1, random_fields());
    endtask

    task automatic test_directed_frames();
        send_frame(0, 0, 0, {8'hFF, 8'h80, 8'h7F, 8'h80, 8'h80});
        send_frame(0, 0, 0, {8'h00, 8'h7F, 8'h80, 8'h7F, 8'h7F});
        send_frame(0, 0, 0, {8'h01, 8'hFF, 8'h01, 8'hFF, 8'h00});
        send_frame(1, 0, 0, random_fields());
        send_frame(0, 1, 0, random_fields());
        send_frame(0, 0, 1, random_fields());
        // checksum outranks start, start outranks marker
        send_frame(1, 1, 1, random_fields());
        send_frame(0, 1, 1, random_fields());
    endtask

    task automatic test_register_timing();
        write_reg(CFG_UNMAPPED, 8'($urandom_range(0, 255)));
        send_frame(0, 0, 0, random_fields());
        align_frame();
        build_frame(0, 0, 0, random_fields());
        // start byte already compared; offset applies at the report
        send_span(0, 2);
        write_reg(jfc_pkg::CFG_START_VALUE, ~reg_start);
        write_reg(jfc_pkg::CFG_THRUST_OFFSET, 8'($urandom_range(0, 255)));
        send_span(3, 5);
        // marker not yet seen, so the new value counts for this frame
        write_reg(jfc_pkg::CFG_MARKER_VALUE, reg_marker ^ 8'h5A);
        send_span(6, FRAME_BYTES - 1);
        send_frame(0, 0, 0, random_fields());
    endtask

    task automatic test_config_sweep();
        logic [jfc_pkg::BYTE_W-1:0] sweep [4][3];
        sweep[0] = '{8'h00, 8'h00, 8'h00};
        sweep[1] = '{8'hFF, 8'hFF, 8'hFF};
        sweep[2] = '{8'($urandom), 8'($urandom), 8'($urandom)};
        sweep[3] = '{jfc_pkg::START_VALUE_RST, jfc_pkg::MARKER_VALUE_RST,
                     jfc_pkg::THRUST_OFFSET_RST};
        for (int s = 0; s < 4; s++) begin
            write_reg(jfc_pkg::CFG_START_VALUE, sweep[s][0]);
            write_reg(jfc_pkg::CFG_MARKER_VALUE, sweep[s][1]);
            write_reg(jfc_pkg::CFG_THRUST_OFFSET, sweep[s][2]);
            repeat (10) send_random_frame();
        end
    endtask

    task automatic test_backpressure();
        idle_on   = 1'b0;
        hold_left = 300;
        repeat (6) send_frame(0, 0, 0, random_fields());
        idle_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (3) begin
            repeat (4) send_random_frame();
            wait_drained();
        end
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int first;
        first   = bytes_sent;
        idle_on = 1'b1;
        while (bytes_sent - first < n_bytes) begin
            // full rate on both sides for the tail of the run
            if (bytes_sent - first > n_bytes - 200) idle_on = 1'b0;
            if (idle_on && $urandom_range(0, 29) == 0)
                write_reg(jfc_pkg::CFG_IDX_W'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)));
            send_random_frame();
        end
    endtask

    initial begin
        reset_decoder();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_frames();
        test_register_timing();
        test_config_sweep();
        test_backpressure();
        test_drain_pause();
        test_random_traffic(600);
        rx_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d bytes in, %0d reports checked: ok %0d, checksum %0d, start %0d, marker %0d",
                 bytes_sent, reports_seen, status_seen[jfc_pkg::STAT_OK],
                 status_seen[jfc_pkg::STAT_CHECKSUM], status_seen[jfc_pkg::STAT_START],
                 status_seen[jfc_pkg::STAT_MARKER]);
        $display("%0d register writes, %0d cycles with the byte input stalled",
                 cfg_writes, stall_cycles);
        if (err_count == 0) begin
            $display("tb_joystick_frame_checker_unit: done, clean");
        end else begin
            $display("tb_joystick_frame_checker_unit: done, errors");
        end
        $finish;
    end

endmodule
